>>> sv/sps_pkg.sv
`timescale 1ns / 1ps

package sps_pkg;

  // result status codes
  typedef enum logic [1:0] {
    StatusOk       = 2'd0,
    StatusInvalid  = 2'd1,
    StatusOverflow = 2'd2
  } status_e;

  // sequencer states, one-hot
  typedef enum logic [6:0] {
    StIdle = 7'b0000001,
    StDiv  = 7'b0000010,
    StMul  = 7'b0000100,
    StRedA = 7'b0001000,
    StRedB = 7'b0010000,
    StChk  = 7'b0100000,
    StFin  = 7'b1000000
  } state_e;

endpackage

>>> sv/scaler_phase_step_calc.sv
`timescale 1ns / 1ps

// Scaler phase step calculator.
// Input channel: one beat carries src_size_i and dst_size_i, taken when
// in_valid_i is high and in_stall_o is low. Output channel: one beat per input
// beat with phase_step_o = floor(2^PHASE_SHIFT * src / dst) mod 2^32 and
// status_o (ok, invalid zero size, possible phase overflow).
// One item is worked at a time; in_stall_o is high from acceptance until the
// result moves into the output register. The quotient comes from a restoring
// divider that yields one bit per cycle. A downscale item then passes the
// multiply, first reduction, second reduction (skipped when no reduction is
// needed) and check states before the finish state; an upscale item goes from
// the divider to the finish state, and a zero size goes straight there. The
// overflow check uses one 32x17 multiply and up to two reduction steps.
// The output register holds a finished beat while out_stall_i is high; the
// next item may be accepted and computed meanwhile, and waits at the end of
// its sequence until the output register frees up.
// Reset clears the sequencer and output valid; nothing else needs clearing.
module scaler_phase_step_calc import sps_pkg::*; #(
  parameter int PHASE_SHIFT = 21
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [15:0] src_size_i,
  input  logic [15:0] dst_size_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [31:0] phase_step_o,
  output logic [1:0]  status_o
);

  localparam logic [31:0] Unit  = 32'd1 << PHASE_SHIFT;
  localparam logic [31:0] Limit = Unit + (Unit >> 1);
  localparam logic [31:0] Mask  = Unit - 32'd1;

  state_e      state_q, state_d;
  logic [15:0] src_q, src_d;
  logic [15:0] dst_q, dst_d;
  logic [31:0] step_q, step_d;
  logic [31:0] res_q, res_d;
  logic [31:0] r_q, r_d;
  logic [32:0] sum_q, sum_d;
  status_e     status_q, status_d;
  logic        ovld_q, ovld_d;
  logic [31:0] ostep_q, ostep_d;
  status_e     ostat_q, ostat_d;

  logic        in_acc;
  logic        out_free;
  logic        div_done;
  logic [31:0] div_quot;
  logic [16:0] dst_p1;
  logic [48:0] prod;

  assign in_acc   = in_valid_i && (state_q == StIdle);
  assign out_free = !ovld_q || !out_stall_i;

  // bit-serial divider
  sps_div #(
    .PHASE_SHIFT(PHASE_SHIFT)
  ) u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(in_acc && (src_size_i != 16'd0) && (dst_size_i != 16'd0)),
    .src_i  (src_size_i),
    .dst_i  (dst_size_i),
    .done_o (div_done),
    .quot_o (div_quot)
  );

  // residue * (dst + 1), low 32 bits
  always_comb begin
    dst_p1 = {1'b0, dst_q} + 17'd1;
    prod   = {17'b0, res_q} * {32'b0, dst_p1};
  end

  // sequencer
  always_comb begin
    state_d  = state_q;
    src_d    = src_q;
    dst_d    = dst_q;
    step_d   = step_q;
    res_d    = res_q;
    r_d      = r_q;
    sum_d    = sum_q;
    status_d = status_q;
    ovld_d   = ovld_q && out_stall_i;
    ostep_d  = ostep_q;
    ostat_d  = ostat_q;
    unique case (state_q)
      StIdle: begin
        if (in_valid_i) begin
          src_d = src_size_i;
          dst_d = dst_size_i;
          if ((src_size_i == 16'd0) || (dst_size_i == 16'd0)) begin
            step_d   = '0;
            status_d = StatusInvalid;
            state_d  = StFin;
          end else begin
            state_d = StDiv;
          end
        end
      end
      StDiv: begin
        if (div_done) begin
          step_d = div_quot;
          res_d  = div_quot - Unit;
          if (src_q > dst_q) begin
            state_d = StMul;
          end else begin
            status_d = StatusOk;
            state_d  = StFin;
          end
        end
      end
      StMul: begin
        r_d     = prod[31:0];
        state_d = StRedA;
      end
      StRedA: begin
        // round the excess up to whole units
        sum_d = {1'b0, r_q - Limit} + {1'b0, Mask};
        if (r_q > Limit) begin
          state_d = StRedB;
        end else begin
          state_d = StChk;
        end
      end
      StRedB: begin
        r_d     = r_q - (sum_q[31:0] & ~Mask);
        state_d = StChk;
      end
      StChk: begin
        status_d = ((r_q > res_q) && (r_q < Unit)) ? StatusOverflow : StatusOk;
        state_d  = StFin;
      end
      StFin: begin
        if (out_free) begin
          ovld_d  = 1'b1;
          ostep_d = step_q;
          ostat_d = status_q;
          state_d = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      ovld_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      ovld_q  <= ovld_d;
    end
  end

  // working and output payload registers
  always_ff @(posedge clk_i) begin
    src_q    <= src_d;
    dst_q    <= dst_d;
    step_q   <= step_d;
    res_q    <= res_d;
    r_q      <= r_d;
    sum_q    <= sum_d;
    status_q <= status_d;
    ostep_q  <= ostep_d;
    ostat_q  <= ostat_d;
  end

  assign in_stall_o   = (state_q != StIdle);
  assign out_valid_o  = ovld_q;
  assign phase_step_o = ostep_q;
  assign status_o     = ostat_q;

endmodule

>>> sv/sps_div.sv
`timescale 1ns / 1ps

// restoring divider, one quotient bit per cycle: (src << PHASE_SHIFT) / dst
module sps_div import sps_pkg::*; #(
  parameter int PHASE_SHIFT = 21
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [15:0] src_i,
  input  logic [15:0] dst_i,
  output logic        done_o,
  output logic [31:0] quot_o
);

  localparam int NumBits = PHASE_SHIFT + 16;
  localparam int CntW    = $clog2(NumBits + 1);

  logic            busy_q, busy_d;
  logic            done_q, done_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic [15:0]     num_q, num_d;
  logic [15:0]     dvsr_q, dvsr_d;
  logic [16:0]     rem_q, rem_d;
  logic [31:0]     quot_q, quot_d;
  logic [16:0]     rem_sh;
  logic [16:0]     diff;
  logic            ge;

  // shared compare and subtract
  always_comb begin
    rem_sh = {rem_q[15:0], num_q[15]};
    diff   = rem_sh - {1'b0, dvsr_q};
    ge     = rem_sh >= {1'b0, dvsr_q};
  end

  // iteration control
  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    num_d  = num_q;
    dvsr_d = dvsr_q;
    rem_d  = rem_q;
    quot_d = quot_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = CntW'(NumBits);
      num_d  = src_i;
      dvsr_d = dst_i;
      rem_d  = '0;
      quot_d = '0;
    end else if (busy_q) begin
      num_d  = {num_q[14:0], 1'b0};
      rem_d  = ge ? diff : rem_sh;
      quot_d = {quot_q[30:0], ge};
      cnt_d  = cnt_q - CntW'(1);
      if (cnt_q == CntW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    num_q  <= num_d;
    dvsr_q <= dvsr_d;
    rem_q  <= rem_d;
    quot_q <= quot_d;
  end

  assign done_o = done_q;
  assign quot_o = quot_q;

endmodule
